// ----- hdl/dta_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_pkg
// Shared types and constants of the delayed threshold alarm.
// ----------------------------------------------------------------------------
package dta_pkg;

  // field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 8;

  // q16.16 one, the value of a good quality sample
  localparam logic [VALUE_W-1:0] Q16_ONE = 32'h0001_0000;

  // condition codes
  typedef enum logic [1:0] {
    COND_BELOW = 2'd0,
    COND_EQUAL = 2'd1,
    COND_ABOVE = 2'd2
  } cond_mode_t;

  // event codes
  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_ACTIVATED = 2'd1,
    EV_CLEARED   = 2'd2
  } event_code_t;

  // input beat kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ACK    = 1'b1;

  // source modes
  localparam logic SRC_VALUE   = 1'b0;
  localparam logic SRC_QUALITY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COND_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE = 2'd3;

  // configuration as seen by the alarm core
  typedef struct packed {
    logic [1:0]         cond_mode;
    logic [VALUE_W-1:0] threshold;
    logic [DELAY_W-1:0] delay_seconds;
    logic               source_mode;
  } dta_cfg_t;

  // one result, packed lowest field in bit 0
  typedef struct packed {
    logic        blinking;
    logic [1:0]  event_code;
    logic        is_acknowledged;
    logic        is_active;
  } dta_result_t;

endpackage : dta_pkg
`default_nettype wire

// ----- hdl/delayed_threshold_alarm.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted input beat passes the input register, then the output register.
// One beat per cycle while out_tready lets the output drain; the alarm state
// updates as each beat moves from the input into the output register.
// Reset: synchronous active-low rst_n clears the alarm flags, the pending
// start time, all configuration registers and both pipeline valids.
// ----------------------------------------------------------------------------
// delayed_threshold_alarm
// Threshold alarm with activation delay and operator acknowledge; a stream
// in, one result beat out for every input beat.
// ----------------------------------------------------------------------------
module delayed_threshold_alarm (
  input  wire                                clk,
  input  wire                                rst_n,
  // configuration write port
  input  wire                                cfg_wr_en,
  input  wire  [dta_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [dta_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [dta_pkg::IN_DATA_W-1:0]      in_tdata,   // sample_value[31:0], now_seconds[63:32]
  input  wire                                in_tuser,   // kind
  // result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [dta_pkg::OUT_DATA_W-1:0]     out_tdata   // is_active, is_acknowledged,
                                                         // event_code[1:0], blinking, pad
);

  dta_pkg::dta_cfg_t            cfg_r;

  logic                         s1_valid_r;
  logic                         s1_kind_r;
  logic [dta_pkg::VALUE_W-1:0]  s1_sample_r;
  logic [dta_pkg::TIME_W-1:0]   s1_now_r;
  logic                         s1_move;

  dta_pkg::dta_result_t         step_result;
  dta_pkg::dta_result_t         out_result_r;
  logic                         out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        dta_pkg::REG_COND_MODE:   cfg_r.cond_mode     <= cfg_wdata[1:0];
        dta_pkg::REG_THRESHOLD:   cfg_r.threshold     <= cfg_wdata[dta_pkg::VALUE_W-1:0];
        dta_pkg::REG_DELAY:       cfg_r.delay_seconds <= cfg_wdata[dta_pkg::DELAY_W-1:0];
        dta_pkg::REG_SOURCE_MODE: cfg_r.source_mode   <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // handshake: a beat leaves the input register when the output slot frees
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r   <= in_tuser;
      s1_sample_r <= in_tdata[dta_pkg::VALUE_W-1:0];
      s1_now_r    <= in_tdata[dta_pkg::IN_DATA_W-1:dta_pkg::VALUE_W];
    end
  end

  // alarm update
  dta_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (s1_move),
    .cfg          (cfg_r),
    .kind         (s1_kind_r),
    .sample_value (s1_sample_r),
    .now_seconds  (s1_now_r),
    .result       (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_result_r <= step_result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dta_pkg::OUT_DATA_W - $bits(dta_pkg::dta_result_t)){1'b0}},
                       out_result_r};

endmodule : delayed_threshold_alarm
`default_nettype wire

// ----- hdl/dta_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dta_core
// Alarm state and the per-beat update: threshold compare, delay check,
// flag updates. The result is combinational; state moves on step_en.
// ----------------------------------------------------------------------------
module dta_core (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                step_en,
  input  dta_pkg::dta_cfg_t                  cfg,
  input  wire                                kind,
  input  wire  [dta_pkg::VALUE_W-1:0]        sample_value,
  input  wire  [dta_pkg::TIME_W-1:0]         now_seconds,
  output dta_pkg::dta_result_t               result
);

  logic                        pending_r, pending_nxt;
  logic                        active_r, active_nxt;
  logic                        acked_r, acked_nxt;
  logic [dta_pkg::TIME_W-1:0]  since_r, since_nxt;

  logic [dta_pkg::VALUE_W-1:0] cmp_val;
  logic                        lt, eq, gt;
  logic                        cond_hold, cond_fail;
  logic [dta_pkg::TIME_W-1:0]  start_time;
  logic [dta_pkg::TIME_W-1:0]  elapsed;
  logic                        delay_done;
  dta_pkg::event_code_t        ev;

  // value under test: raw sample or quality mapped to 1.0 / 0.0
  always_comb begin
    if (cfg.source_mode == dta_pkg::SRC_QUALITY) begin
      cmp_val = (sample_value != '0) ? dta_pkg::Q16_ONE : '0;
    end else begin
      cmp_val = sample_value;
    end
  end

  assign lt = $signed(cmp_val) <  $signed(cfg.threshold);
  assign eq = cmp_val == cfg.threshold;
  assign gt = $signed(cmp_val) >  $signed(cfg.threshold);

  // condition select; the unused code neither holds nor fails
  always_comb begin
    case (cfg.cond_mode)
      dta_pkg::COND_BELOW: begin
        cond_hold = lt;
        cond_fail = !lt;
      end
      dta_pkg::COND_EQUAL: begin
        cond_hold = eq;
        cond_fail = !eq;
      end
      dta_pkg::COND_ABOVE: begin
        cond_hold = gt;
        cond_fail = !gt;
      end
      default: begin
        cond_hold = 1'b0;
        cond_fail = 1'b0;
      end
    endcase
  end

  // elapsed time since the condition began, modulo 2^32
  assign start_time = pending_r ? since_r : now_seconds;
  assign elapsed    = now_seconds - start_time;
  assign delay_done = elapsed >= {{(dta_pkg::TIME_W-dta_pkg::DELAY_W){1'b0}}, cfg.delay_seconds};

  // next state and event
  always_comb begin
    pending_nxt = pending_r;
    active_nxt  = active_r;
    acked_nxt   = acked_r;
    since_nxt   = since_r;
    ev          = dta_pkg::EV_NONE;
    if (kind == dta_pkg::KIND_ACK) begin
      acked_nxt = 1'b1;
      if (!active_r) begin
        ev = dta_pkg::EV_CLEARED;
      end
    end else if (cfg.source_mode == dta_pkg::SRC_VALUE) begin
      if (cond_hold) begin
        if (!pending_r) begin
          pending_nxt = 1'b1;
          since_nxt   = now_seconds;
        end
        if (!active_r && delay_done) begin
          active_nxt = 1'b1;
          acked_nxt  = 1'b0;
          ev         = dta_pkg::EV_ACTIVATED;
        end
      end else if (cond_fail) begin
        pending_nxt = 1'b0;
        if (active_r) begin
          active_nxt = 1'b0;
          ev         = dta_pkg::EV_CLEARED;
        end
      end
    end else begin
      if (cond_hold && !active_r) begin
        active_nxt = 1'b1;
        acked_nxt  = 1'b0;
        ev         = dta_pkg::EV_ACTIVATED;
      end else if (cond_fail && active_r) begin
        active_nxt = 1'b0;
        acked_nxt  = 1'b0;
        ev         = dta_pkg::EV_CLEARED;
      end
    end
  end

  // result after this beat
  always_comb begin
    result.is_active       = active_nxt;
    result.is_acknowledged = acked_nxt;
    result.event_code      = ev;
    result.blinking        = active_nxt && !acked_nxt;
  end

  // alarm state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      active_r  <= 1'b0;
      acked_r   <= 1'b0;
      since_r   <= '0;
    end else if (step_en) begin
      pending_r <= pending_nxt;
      active_r  <= active_nxt;
      acked_r   <= acked_nxt;
      since_r   <= since_nxt;
    end
  end

`ifndef SYNTH
  // acknowledge always leaves the flag set
  a_ack_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && kind == dta_pkg::KIND_ACK |=> acked_r)
    else $error("acknowledge did not set the flag");

  // activation leaves an active, unacknowledged alarm
  a_activate: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.event_code == dta_pkg::EV_ACTIVATED |=> active_r && !acked_r)
    else $error("activation event without active alarm");

  // a new pending condition captures the sample time
  a_pending_start: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && kind == dta_pkg::KIND_SAMPLE && cfg.source_mode == dta_pkg::SRC_VALUE
      && cond_hold && !pending_r
    |=> pending_r && since_r == $past(now_seconds))
    else $error("pending start time not captured");

  // state is idle after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !active_r && !acked_r && !pending_r)
    else $error("alarm state not cleared by reset");
`endif

endmodule : dta_core
`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delayed_threshold_alarm: a directed table covers the
// register extremes, every condition and source mode, the unused condition,
// acknowledge on both alarm states and the wrap of elapsed time; random
// streams follow under changing settings and idling. Every result beat is
// compared field by field with its typed row or an in-bench alarm model.
// ----------------------------------------------------------------------------
module testbench;
  import dta_pkg::*;

  localparam logic [1:0] COND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PRESSURE_BEATS = 24;
  localparam int SEGMENTS       = 4;
  localparam int SEGMENT_BEATS  = 65;

  // one register setting
  typedef struct packed {
    logic [1:0]         cond;
    logic [VALUE_W-1:0] thr;
    logic [DELAY_W-1:0] dly;
    logic               src;
  } alarm_setting_t;

  // one directed beat; act, ackd and ev only count where typed is set
  typedef struct packed {
    logic [2:0]         setting;
    logic               kind;
    logic [VALUE_W-1:0] sample;
    logic [TIME_W-1:0]  now;
    logic               typed;
    logic               act;
    logic               ackd;
    event_code_t        ev;
  } stim_row_t;

  localparam alarm_setting_t DIRECTED_SETTINGS [0:6] = '{
    '{COND_BELOW,  32'h0000_0000, 16'd0,     SRC_VALUE},
    '{COND_ABOVE,  32'h7FFF_FFFE, 16'hFFFF,  SRC_VALUE},
    '{COND_EQUAL,  32'h8000_0000, 16'd3,     SRC_VALUE},
    '{COND_EQUAL,  Q16_ONE,       16'd0,     SRC_QUALITY},
    '{COND_UNUSED, 32'h0000_0000, 16'hFFFF,  SRC_QUALITY},
    '{COND_UNUSED, 32'h0000_0000, 16'd0,     SRC_VALUE},
    '{COND_BELOW,  32'h7FFF_FFFF, 16'd0,     SRC_VALUE}
  };

  localparam stim_row_t DIRECTED_ROWS [0:23] = '{
    // default setting: removal, activation, acknowledge, deactivation
    '{0, KIND_ACK,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 1, EV_CLEARED},
    '{0, KIND_SAMPLE, 32'h8000_0000, 32'h0000_0000, 1, 1, 0, EV_ACTIVATED},
    '{0, KIND_ACK,    32'h0000_0000, 32'h0000_0000, 1, 1, 1, EV_NONE},
    '{0, KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0001, 1, 0, 1, EV_CLEARED},
    '{0, KIND_SAMPLE, 32'h0000_0000, 32'hFFFF_FFFF, 1, 0, 1, EV_NONE},
    // longest delay, elapsed time wrapping past zero
    '{1, KIND_SAMPLE, 32'h7FFF_FFFF, 32'hFFFF_FFF0, 1, 0, 1, EV_NONE},
    '{1, KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0000_FFEF, 1, 1, 0, EV_ACTIVATED},
    '{1, KIND_SAMPLE, 32'h7FFF_FFFE, 32'h0001_0000, 1, 0, 0, EV_CLEARED},
    '{1, KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0064, 0, 0, 0, EV_NONE},
    '{1, KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0001_0062, 0, 0, 0, EV_NONE},
    // equal to the lowest threshold, pending start carried over
    '{2, KIND_SAMPLE, 32'h8000_0000, 32'h0000_0005, 0, 0, 0, EV_NONE},
    '{2, KIND_SAMPLE, 32'h0000_0000, 32'h0000_0006, 0, 0, 0, EV_NONE},
    '{2, KIND_SAMPLE, 32'h8000_0000, 32'h0000_000A, 0, 0, 0, EV_NONE},
    '{2, KIND_SAMPLE, 32'h8000_0000, 32'h0000_000D, 0, 0, 0, EV_NONE},
    '{2, KIND_ACK,    32'h1234_5678, 32'h0000_000E, 0, 0, 0, EV_NONE},
    // quality source
    '{3, KIND_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1, 0, 0, EV_CLEARED},
    '{3, KIND_SAMPLE, 32'h0000_1234, 32'h0000_0000, 1, 1, 0, EV_ACTIVATED},
    '{3, KIND_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0, 0, EV_NONE},
    '{3, KIND_ACK,    32'h0000_0000, 32'h0000_0000, 1, 1, 1, EV_NONE},
    // unused condition leaves everything alone
    '{4, KIND_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1, 1, 1, EV_NONE},
    '{5, KIND_SAMPLE, 32'h8000_0000, 32'h0000_0000, 1, 1, 1, EV_NONE},
    '{5, KIND_ACK,    32'h0000_0000, 32'h0000_0000, 1, 1, 1, EV_NONE},
    // below the highest threshold
    '{6, KIND_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0007, 1, 0, 1, EV_CLEARED},
    '{6, KIND_SAMPLE, 32'h7FFF_FFFE, 32'h0000_0000, 1, 1, 0, EV_ACTIVATED}
  };

  // dut ports
  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // sample_value[31:0], now_seconds[63:32]
  logic                  in_tuser   = 1'b0; // kind
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // is_active, is_acknowledged,
                                            // event_code[1:0], blinking, pad

  // typed expectation riding along with the input beat
  logic        beat_typed = 1'b0;
  dta_result_t beat_want  = '0;

  // model copy of the registers and the alarm state
  logic [1:0]                watch_cond      = COND_BELOW;
  logic signed [VALUE_W-1:0] watch_threshold = '0;
  logic [DELAY_W-1:0]        watch_delay     = '0;
  logic                      watch_source    = SRC_VALUE;
  logic                      pending_on      = 1'b0;
  logic                      alarm_on        = 1'b0;
  logic                      acked           = 1'b0;
  logic [TIME_W-1:0]         pending_start   = '0;

  dta_result_t       alarm_results[$];
  logic [TIME_W-1:0] clock_now     = '0;
  int                mismatch_count = 0;
  int                results_seen   = 0;
  int                idle_cycles    = 0;
  int                tx_idle_pct    = 0;
  int                rx_idle_pct    = 0;
  bit                stall_req      = 1'b0;

  delayed_threshold_alarm i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 1 holds, 0 fails, -1 neither
  function automatic int judge(logic signed [VALUE_W-1:0] v);
    case (watch_cond)
      COND_BELOW: return (v < watch_threshold) ? 1 : 0;
      COND_EQUAL: return (v == watch_threshold) ? 1 : 0;
      COND_ABOVE: return (v > watch_threshold) ? 1 : 0;
      default:    return -1;
    endcase
  endfunction

  // advance the alarm by one beat and return its result
  function automatic dta_result_t alarm_step(logic kind, logic [VALUE_W-1:0] sample,
                                             logic [TIME_W-1:0] now);
    dta_result_t       r;
    int                verdict;
    event_code_t       ev;
    logic [TIME_W-1:0] elapsed;
    ev = EV_NONE;
    if (kind == KIND_ACK) begin
      acked = 1'b1;
      if (!alarm_on) ev = EV_CLEARED;
    end else if (watch_source == SRC_VALUE) begin
      verdict = judge(sample);
      if (verdict == 1) begin
        if (!pending_on) begin
          pending_on    = 1'b1;
          pending_start = now;
        end
        elapsed = now - pending_start;
        if (!alarm_on && elapsed >= TIME_W'(watch_delay)) begin
          alarm_on = 1'b1;
          acked    = 1'b0;
          ev       = EV_ACTIVATED;
        end
      end else if (verdict == 0) begin
        pending_on = 1'b0;
        if (alarm_on) begin
          alarm_on = 1'b0;
          ev       = EV_CLEARED;
        end
      end
    end else begin
      // quality: any nonzero sample counts as one
      verdict = judge(sample != '0 ? Q16_ONE : '0);
      if (verdict == 1 && !alarm_on) begin
        alarm_on = 1'b1;
        acked    = 1'b0;
        ev       = EV_ACTIVATED;
      end else if (verdict == 0 && alarm_on) begin
        alarm_on = 1'b0;
        acked    = 1'b0;
        ev       = EV_CLEARED;
      end
    end
    r.is_active       = alarm_on;
    r.is_acknowledged = acked;
    r.event_code      = ev;
    r.blinking        = alarm_on & ~acked;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                results_seen, name, got, want));
  endtask

  // compare result beats, then predict accepted input beats
  always @(posedge clk) begin
    dta_result_t got;
    dta_result_t want;
    dta_result_t pred;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = dta_result_t'(out_tdata[4:0]);
        if (alarm_results.size() == 0) begin
          report_mismatch($sformatf("result beat %02h with none expected", out_tdata));
        end else begin
          want = alarm_results.pop_front();
          check_field("is_active", got.is_active, want.is_active);
          check_field("is_acknowledged", got.is_acknowledged, want.is_acknowledged);
          check_field("event_code", got.event_code, want.event_code);
          check_field("blinking", got.blinking, want.blinking);
        end
        results_seen++;
      end
      if (in_tvalid && in_tready) begin
        pred = alarm_step(in_tuser, in_tdata[VALUE_W-1:0], in_tdata[IN_DATA_W-1:VALUE_W]);
        alarm_results = {alarm_results, (beat_typed ? beat_want : pred)};
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request
  always begin
    @(posedge clk);
    if (stall_req) begin
      out_tready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
      stall_req = 1'b0;
    end else begin
      out_tready <= (rx_idle_pct == 0) || ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("delayed_threshold_alarm verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // write all registers and mirror them in the model
  task automatic apply_setting(alarm_setting_t s);
    write_reg(REG_COND_MODE,   CFG_DATA_W'(s.cond));
    write_reg(REG_THRESHOLD,   s.thr);
    write_reg(REG_DELAY,       CFG_DATA_W'(s.dly));
    write_reg(REG_SOURCE_MODE, CFG_DATA_W'(s.src));
    cfg_wr_en       <= 1'b0;
    watch_cond      = s.cond;
    watch_threshold = s.thr;
    watch_delay     = s.dly;
    watch_source    = s.src;
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (alarm_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // offer one beat, with a random gap ahead of it
  task automatic send_beat(logic kind, logic [VALUE_W-1:0] sample, logic [TIME_W-1:0] now,
                           logic typed, dta_result_t want);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= kind;
    in_tdata   <= {now, sample};
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk); while (!in_tready);
  endtask

  // samples cluster around the threshold so the condition flips often
  function automatic logic [VALUE_W-1:0] next_sample();
    case ($urandom_range(9))
      0, 1, 2: return watch_threshold;
      3, 4, 5: return watch_threshold + VALUE_W'($urandom_range(6)) - VALUE_W'(3);
      6:       return '0;
      7:       return Q16_ONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic alarm_setting_t random_setting();
    alarm_setting_t s;
    s.cond = ($urandom_range(9) == 0) ? COND_UNUSED : 2'($urandom_range(2));
    case ($urandom_range(5))
      0:       s.thr = '0;
      1:       s.thr = Q16_ONE;
      2:       s.thr = 32'h8000_0000;
      3:       s.thr = 32'h7FFF_FFFF;
      default: s.thr = $urandom;
    endcase
    case ($urandom_range(4))
      0:       s.dly = '0;
      1:       s.dly = 16'hFFFF;
      default: s.dly = DELAY_W'($urandom_range(12));
    endcase
    s.src = 1'($urandom_range(1));
    return s;
  endfunction

  // acknowledges now and then; samples mostly on a steady clock with small steps, now and then a jump
  task automatic send_random();
    if ($urandom_range(99) < 15) begin
      send_beat(KIND_ACK, $urandom, $urandom, 1'b0, '0);
    end else begin
      case ($urandom_range(19))
        0:       clock_now = $urandom;
        1:       clock_now += TIME_W'($urandom_range(70000));
        default: clock_now += TIME_W'($urandom_range(4));
      endcase
      send_beat(KIND_SAMPLE, next_sample(), clock_now, 1'b0, '0);
    end
  endtask

  // stimulus
  initial begin
    int          row_setting;
    stim_row_t   row;
    dta_result_t want;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    row_setting = -1;
    foreach (DIRECTED_ROWS[i]) begin
      row = DIRECTED_ROWS[i];
      if (int'(row.setting) != row_setting) begin
        wait_quiet();
        apply_setting(DIRECTED_SETTINGS[row.setting]);
        row_setting = row.setting;
      end
      want.is_active       = row.act;
      want.is_acknowledged = row.ackd;
      want.event_code      = row.ev;
      want.blinking        = row.act & ~row.ackd;
      send_beat(row.kind, row.sample, row.now, row.typed, want);
    end

    // random streams, three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 33; rx_idle_pct = 59; end
        1:       begin tx_idle_pct = 59; rx_idle_pct = 33; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      // long receiver hold-off while beats keep coming
      if (phase == 2) begin
        stall_req = 1'b1;
        repeat (PRESSURE_BEATS) send_random();
      end
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_quiet();
        apply_setting(random_setting());
        clock_now = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - TIME_W'($urandom_range(20))
                                             : TIME_W'($urandom);
        repeat (SEGMENT_BEATS) send_random();
      end
    end

    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("delayed_threshold_alarm verification clean");
    end else begin
      $display("delayed_threshold_alarm verification failed");
    end
    $finish;
  end

endmodule

// ----- delayed_threshold_alarm.f -----
hdl/dta_pkg.sv
hdl/dta_core.sv
hdl/delayed_threshold_alarm.sv
tb/sv/testbench.sv
